>>> rtl/wsfe_pkg.sv
// Shared constants, types and helpers for the windowed slope feature extractor.
`default_nettype none
package wsfe_pkg;

    localparam int WINDOW_MAX     = 64;
    localparam int FRAC_BITS      = 16;
    localparam int SLOT_W         = $clog2(WINDOW_MAX);
    localparam int CNT_W          = $clog2(WINDOW_MAX + 1);
    localparam int DEFAULT_WINDOW = 12;
    localparam int MIN_FIT_POINTS = 3;
    localparam int MS_PER_S       = 1000;
    localparam int DATA_W         = 32;
    localparam int TIME_W         = 48;
    localparam int STEP_W         = 31;
    localparam int WLEN_W         = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int WIDE_W         = 112;
    localparam int MB_W           = 64;
    localparam int DT_W           = TIME_W + 1;
    localparam int DV_W           = DATA_W + 1;
    localparam int SX_W           = DT_W + CNT_W;
    localparam int SV_W           = DV_W + CNT_W;
    localparam int MEM_W          = 1 + DATA_W + DATA_W + TIME_W;
    localparam int MUL_DIGIT      = 8;
    localparam int MUL_STEPS      = MB_W / MUL_DIGIT;
    localparam int MUL_CNT_W      = $clog2(MUL_STEPS + 1);
    localparam int DIV_CNT_W      = $clog2(WIDE_W + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THERMAL_COEF,
        REG_REF_TEMP,
        REG_VENT_STEP,
        REG_WINDOW_LEN
    } cfg_reg_t;

    typedef enum logic [3:0] {
        MS_CORR,
        MS_DTDT,
        MS_DTDL,
        MS_DTDP,
        MS_NSXX,
        MS_SXSX,
        MS_NSXL,
        MS_SXSL,
        MS_KL,
        MS_NSXP,
        MS_SXSP,
        MS_KP
    } mul_sel_t;

    typedef enum logic [1:0] {
        DS_LEVEL,
        DS_TEMP,
        DS_RATIO
    } div_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_STORE,
        ST_READ,
        ST_TAKE,
        ST_NEXT,
        ST_DIV,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic     capture;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     store;
        logic     read;
        logic     take;
        logic     advance;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic entry_vent;
        logic last_entry;
        logic fit_points;
        logic den_pos;
        logic out_busy;
    } dp_status_t;

    function automatic logic [DATA_W-1:0] sat32(input logic [WIDE_W-1:0] v);
        logic [DATA_W-1:0] r;
        if ((&v[WIDE_W-1:DATA_W-1]) || (~|v[WIDE_W-1:DATA_W-1]))
        begin
            r = v[DATA_W-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/windowed_slope_feature_extractor.sv
// Top level of the windowed slope feature extractor: controller plus datapath.
//
//  channel   handshake              payload
//  -------   ---------------------  --------------------------------------------------
//  input     in_valid / in_stall    return_temp supply_temp raw_level pump_speed
//                                   sample_time
//  output    out_valid / out_stall  temp_difference corrected_level level_slope
//                                   temp_slope speed_ratio vent_now vent_in_window
//  config    cfg_we                 cfg_index cfg_data
//
// One item at a time on the shared 8-bit-digit multiplier: a vent entry of the window
// walk needs no multiply and a fitted entry three, the fit needs 8 more multiplies, then
// one to three divisions follow.
// Reset clears control and config state only; the ring needs no clearing since only
// filled entries are read. A stalled result waits in the output register while the next
// item is taken.
`default_nettype none
module windowed_slope_feature_extractor (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [wsfe_pkg::DATA_W-1:0]   return_temp,
    input  wire logic signed [wsfe_pkg::DATA_W-1:0]   supply_temp,
    input  wire logic signed [wsfe_pkg::DATA_W-1:0]   raw_level,
    input  wire logic signed [wsfe_pkg::DATA_W-1:0]   pump_speed,
    input  wire logic [wsfe_pkg::TIME_W-1:0]          sample_time,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [wsfe_pkg::DATA_W-1:0]        temp_difference,
    output logic signed [wsfe_pkg::DATA_W-1:0]        corrected_level,
    output logic signed [wsfe_pkg::DATA_W-1:0]        level_slope,
    output logic signed [wsfe_pkg::DATA_W-1:0]        temp_slope,
    output logic signed [wsfe_pkg::DATA_W-1:0]        speed_ratio,
    output logic                                      vent_now,
    output logic                                      vent_in_window,
    input  wire logic                                 cfg_we,
    input  wire logic [wsfe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [wsfe_pkg::DATA_W-1:0]          cfg_data
);
    import wsfe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    wsfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    wsfe_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .return_temp     (return_temp),
        .supply_temp     (supply_temp),
        .raw_level       (raw_level),
        .pump_speed      (pump_speed),
        .sample_time     (sample_time),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .temp_difference (temp_difference),
        .corrected_level (corrected_level),
        .level_slope     (level_slope),
        .temp_slope      (temp_slope),
        .speed_ratio     (speed_ratio),
        .vent_now        (vent_now),
        .vent_in_window  (vent_in_window)
    );

endmodule
`default_nettype wire

>>> rtl/wsfe_mul.sv
// Sequential signed multiplier, one 8-bit digit of the second operand per cycle.
`default_nettype none
module wsfe_mul (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [wsfe_pkg::WIDE_W-1:0]  a,
    input  wire logic signed [wsfe_pkg::MB_W-1:0]    b,
    output logic                                     done,
    output logic signed [wsfe_pkg::WIDE_W-1:0]       prod
);
    import wsfe_pkg::*;

    logic                  busy_reg;
    logic [MUL_CNT_W-1:0]  cnt_reg;
    logic [WIDE_W-1:0]     a_reg;
    logic [MB_W-1:0]       b_reg;
    logic [WIDE_W-1:0]     acc_reg;
    logic                  neg_reg;
    logic                  done_reg;
    logic [WIDE_W-1:0]     prod_reg;

    logic [WIDE_W+MUL_DIGIT-1:0] part;
    logic [WIDE_W-1:0]           acc_next;

    assign part     = a_reg * b_reg[MUL_DIGIT-1:0];
    assign acc_next = acc_reg + part[WIDE_W-1:0];
    assign done     = done_reg;
    assign prod     = prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg   <= a[WIDE_W-1] ? -a : a;
            b_reg   <= b[MB_W-1] ? -b : b;
            neg_reg <= a[WIDE_W-1] ^ b[MB_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg   <= a_reg << MUL_DIGIT;
            b_reg   <= b_reg >> MUL_DIGIT;
            acc_reg <= acc_next;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                prod_reg <= neg_reg ? -acc_next : acc_next;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/wsfe_div.sv
// Restoring divider, one quotient bit per cycle, truncating and saturating to 32 bits.
`default_nettype none
module wsfe_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [wsfe_pkg::WIDE_W-1:0]  num,
    input  wire logic [wsfe_pkg::WIDE_W-1:0]         den,
    output logic                                     done,
    output logic [wsfe_pkg::DATA_W-1:0]              quo
);
    import wsfe_pkg::*;

    logic                  busy_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [WIDE_W-1:0]     m_reg;
    logic [WIDE_W-1:0]     d_reg;
    logic [WIDE_W:0]       rem_reg;
    logic [WIDE_W-1:0]     q_reg;
    logic                  neg_reg;
    logic                  done_reg;
    logic [DATA_W-1:0]     quo_reg;

    logic [WIDE_W:0]       rem_sh;
    logic                  fits;
    logic [WIDE_W:0]       rem_next;
    logic [WIDE_W-1:0]     q_next;
    logic [DATA_W-1:0]     q_sat;

    localparam logic [WIDE_W-1:0] POS_LIM = WIDE_W'(64'h7FFF_FFFF);
    localparam logic [WIDE_W-1:0] NEG_LIM = WIDE_W'(64'h8000_0000);

    always_comb
    begin
        rem_sh   = {rem_reg[WIDE_W-1:0], m_reg[WIDE_W-1]};
        fits     = (rem_sh >= {1'b0, d_reg});
        rem_next = fits ? (rem_sh - {1'b0, d_reg}) : rem_sh;
        q_next   = {q_reg[WIDE_W-2:0], fits};
        if (neg_reg)
        begin
            q_sat = (q_next > NEG_LIM) ? NEG_LIM[DATA_W-1:0] : -q_next[DATA_W-1:0];
        end
        else
        begin
            q_sat = (q_next > POS_LIM) ? POS_LIM[DATA_W-1:0] : q_next[DATA_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(WIDE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            m_reg   <= num[WIDE_W-1] ? -num : num;
            neg_reg <= num[WIDE_W-1];
            d_reg   <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            m_reg   <= m_reg << 1;
            rem_reg <= rem_next;
            q_reg   <= q_next;
            if (cnt_reg == DIV_CNT_W'(WIDE_W - 1))
            begin
                quo_reg <= q_sat;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/wsfe_dp.sv
// Datapath: config registers, sample ring, fit sums, shared multiplier and divider, outputs.
`default_nettype none
module wsfe_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire wsfe_pkg::dp_cmd_t                    cmd,
    output wsfe_pkg::dp_status_t                      status,
    input  wire logic                                 cfg_we,
    input  wire logic [wsfe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [wsfe_pkg::DATA_W-1:0]          cfg_data,
    input  wire logic signed [wsfe_pkg::DATA_W-1:0]   return_temp,
    input  wire logic signed [wsfe_pkg::DATA_W-1:0]   supply_temp,
    input  wire logic signed [wsfe_pkg::DATA_W-1:0]   raw_level,
    input  wire logic signed [wsfe_pkg::DATA_W-1:0]   pump_speed,
    input  wire logic [wsfe_pkg::TIME_W-1:0]          sample_time,
    input  wire logic                                 out_stall,
    output logic                                      out_valid,
    output logic signed [wsfe_pkg::DATA_W-1:0]        temp_difference,
    output logic signed [wsfe_pkg::DATA_W-1:0]        corrected_level,
    output logic signed [wsfe_pkg::DATA_W-1:0]        level_slope,
    output logic signed [wsfe_pkg::DATA_W-1:0]        temp_slope,
    output logic signed [wsfe_pkg::DATA_W-1:0]        speed_ratio,
    output logic                                      vent_now,
    output logic                                      vent_in_window
);
    import wsfe_pkg::*;

    // configuration
    logic signed [DATA_W-1:0] coef_reg;
    logic signed [DATA_W-1:0] tref_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [WLEN_W-1:0]        wlen_reg;

    // persistent state
    logic [SLOT_W-1:0]        slot_reg;
    logic [CNT_W-1:0]         filled_reg;
    logic signed [DATA_W-1:0] prev_raw_reg;
    logic                     prev_seen_reg;
    logic signed [DATA_W-1:0] held_reg;

    // current item
    logic signed [DATA_W-1:0] ret_reg;
    logic signed [DATA_W-1:0] sup_reg;
    logic signed [DATA_W-1:0] raw_reg;
    logic signed [DATA_W-1:0] spd_reg;
    logic [TIME_W-1:0]        time_reg;
    logic                     vent_reg;
    logic signed [DATA_W-1:0] corr_reg;

    // window walk
    logic [MEM_W-1:0]         mem [WINDOW_MAX];
    logic [MEM_W-1:0]         rd_reg;
    logic [SLOT_W-1:0]        base_reg;
    logic [SLOT_W-1:0]        idx_reg;
    logic [CNT_W-1:0]         look_reg;
    logic [CNT_W-1:0]         n_reg;
    logic                     vwin_reg;
    logic signed [DT_W-1:0]   dt_reg;
    logic signed [DV_W-1:0]   dl_reg;
    logic signed [DV_W-1:0]   dp_reg;
    logic signed [SX_W-1:0]   sx_reg;
    logic signed [SV_W-1:0]   sl_reg;
    logic signed [SV_W-1:0]   sp_reg;
    logic signed [WIDE_W-1:0] sxx_reg;
    logic signed [WIDE_W-1:0] sxl_reg;
    logic signed [WIDE_W-1:0] sxp_reg;
    logic signed [WIDE_W-1:0] tmp_reg;
    logic signed [WIDE_W-1:0] den_reg;
    logic signed [WIDE_W-1:0] nl_reg;
    logic signed [WIDE_W-1:0] np_reg;

    // results
    logic signed [DATA_W-1:0] lslope_reg;
    logic signed [DATA_W-1:0] tslope_reg;
    logic signed [DATA_W-1:0] ratio_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] o_diff_reg;
    logic signed [DATA_W-1:0] o_corr_reg;
    logic signed [DATA_W-1:0] o_lslope_reg;
    logic signed [DATA_W-1:0] o_tslope_reg;
    logic signed [DATA_W-1:0] o_ratio_reg;
    logic                     o_vent_reg;
    logic                     o_vwin_reg;

    mul_sel_t                 msel_reg;
    div_sel_t                 dsel_reg;

    // shared units
    logic signed [WIDE_W-1:0] mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic                     mul_done;
    logic signed [WIDE_W-1:0] mul_prod;
    logic signed [WIDE_W-1:0] div_num;
    logic [WIDE_W-1:0]        div_den;
    logic                     div_done;
    logic [DATA_W-1:0]        div_quo;

    // combinational helpers
    logic signed [DV_W-1:0]   jump;
    logic [DV_W-1:0]          jump_abs;
    logic                     vent_in;
    logic signed [DV_W-1:0]   diff;
    logic [DV_W-1:0]          diff_mag;
    logic [DV_W-1:0]          diff_clip;
    logic signed [WIDE_W-1:0] corr_wide;
    logic [SLOT_W-1:0]        slot_next;
    logic [CNT_W-1:0]         filled_next;
    logic [CNT_W-1:0]         win;
    logic [SLOT_W:0]          rd_sum;
    logic [SLOT_W-1:0]        rd_addr;
    logic [TIME_W-1:0]        rd_time;
    logic signed [DATA_W-1:0] rd_level;
    logic signed [DATA_W-1:0] rd_temp;
    logic                     rd_vent;
    logic signed [DT_W-1:0]   dt_new;
    logic signed [DV_W-1:0]   dl_new;
    logic signed [DV_W-1:0]   dp_new;
    logic signed [DV_W-1:0]   dtemp_ref;

    assign {rd_vent, rd_temp, rd_level, rd_time} = rd_reg;

    always_comb
    begin
        jump      = DV_W'(raw_level) - DV_W'(prev_raw_reg);
        jump_abs  = jump[DV_W-1] ? -jump : jump;
        vent_in   = prev_seen_reg && (jump_abs > DV_W'(step_reg));
        diff      = DV_W'(sup_reg) - DV_W'(ret_reg);
        diff_mag  = diff[DV_W-1] ? -diff : diff;
        diff_clip = (diff_mag < DV_W'(1 << (FRAC_BITS - 1))) ?
                    DV_W'(1 << (FRAC_BITS - 1)) : diff_mag;
        dtemp_ref = DV_W'(ret_reg) - DV_W'(tref_reg);
        corr_wide = WIDE_W'(raw_reg) - (mul_prod >>> FRAC_BITS);
        slot_next = (slot_reg == SLOT_W'(WINDOW_MAX - 1)) ? '0 : slot_reg + 1'b1;
        filled_next = (32'(filled_reg) < WINDOW_MAX) ? filled_reg + 1'b1 : filled_reg;
        if (wlen_reg < WLEN_W'(MIN_FIT_POINTS))
        begin
            win = CNT_W'(DEFAULT_WINDOW);
        end
        else if (32'(wlen_reg) > WINDOW_MAX)
        begin
            win = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            win = CNT_W'(wlen_reg);
        end
        if (base_reg >= idx_reg)
        begin
            rd_sum = {1'b0, base_reg} - {1'b0, idx_reg};
        end
        else
        begin
            rd_sum = {1'b0, base_reg} + (SLOT_W + 1)'(WINDOW_MAX) - {1'b0, idx_reg};
        end
        rd_addr = rd_sum[SLOT_W-1:0];
        dt_new  = DT_W'({1'b0, rd_time}) - DT_W'({1'b0, time_reg});
        dl_new  = DV_W'(rd_level) - DV_W'(corr_reg);
        dp_new  = DV_W'(rd_temp) - DV_W'(ret_reg);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MS_CORR: begin mul_a = WIDE_W'(coef_reg); mul_b = MB_W'(dtemp_ref); end
            MS_DTDT: begin mul_a = WIDE_W'(dt_reg);   mul_b = MB_W'(dt_reg);    end
            MS_DTDL: begin mul_a = WIDE_W'(dt_reg);   mul_b = MB_W'(dl_reg);    end
            MS_DTDP: begin mul_a = WIDE_W'(dt_reg);   mul_b = MB_W'(dp_reg);    end
            MS_NSXX: begin mul_a = sxx_reg;  mul_b = MB_W'({1'b0, n_reg}); end
            MS_SXSX: begin mul_a = WIDE_W'(sx_reg);   mul_b = MB_W'(sx_reg);    end
            MS_NSXL: begin mul_a = sxl_reg;  mul_b = MB_W'({1'b0, n_reg}); end
            MS_SXSL: begin mul_a = WIDE_W'(sx_reg);   mul_b = MB_W'(sl_reg);    end
            MS_KL:   begin mul_a = nl_reg;   mul_b = MB_W'(MS_PER_S);      end
            MS_NSXP: begin mul_a = sxp_reg;  mul_b = MB_W'({1'b0, n_reg}); end
            MS_SXSP: begin mul_a = WIDE_W'(sx_reg);   mul_b = MB_W'(sp_reg);    end
            MS_KP:   begin mul_a = np_reg;   mul_b = MB_W'(MS_PER_S);      end
            default: begin mul_a = '0;       mul_b = '0;                   end
        endcase
    end

    always_comb
    begin
        div_num = '0;
        div_den = '0;
        unique case (cmd.div_sel)
            DS_LEVEL: begin div_num = nl_reg; div_den = den_reg; end
            DS_TEMP:  begin div_num = np_reg; div_den = den_reg; end
            DS_RATIO:
            begin
                div_num = WIDE_W'(spd_reg) <<< FRAC_BITS;
                div_den = WIDE_W'(diff_clip);
            end
            default:  begin div_num = '0; div_den = '0; end
        endcase
    end

    wsfe_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    wsfe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign status.mul_done   = mul_done;
    assign status.div_done   = div_done;
    assign status.entry_vent = rd_vent;
    assign status.last_entry = ((CNT_W'(idx_reg) + 1'b1) == look_reg);
    assign status.fit_points = (n_reg >= CNT_W'(MIN_FIT_POINTS));
    assign status.den_pos    = !den_reg[WIDE_W-1] && (|den_reg);
    assign status.out_busy   = out_valid_reg && out_stall;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg      <= '0;
            tref_reg      <= '0;
            step_reg      <= STEP_W'(4 << FRAC_BITS);
            wlen_reg      <= WLEN_W'(DEFAULT_WINDOW);
            slot_reg      <= '0;
            filled_reg    <= '0;
            prev_raw_reg  <= '0;
            prev_seen_reg <= 1'b0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_THERMAL_COEF: coef_reg <= cfg_data;
                    REG_REF_TEMP:     tref_reg <= cfg_data;
                    REG_VENT_STEP:    step_reg <= cfg_data[STEP_W-1:0];
                    REG_WINDOW_LEN:   wlen_reg <= cfg_data[WLEN_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.store)
            begin
                slot_reg   <= slot_next;
                filled_reg <= filled_next;
            end
            if (cmd.finish)
            begin
                held_reg      <= lslope_reg;
                prev_raw_reg  <= raw_reg;
                prev_seen_reg <= 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ret_reg    <= return_temp;
            sup_reg    <= supply_temp;
            raw_reg    <= raw_level;
            spd_reg    <= pump_speed;
            time_reg   <= sample_time;
            vent_reg   <= vent_in;
            lslope_reg <= held_reg;
            tslope_reg <= '0;
        end
        if (cmd.mul_start)
        begin
            msel_reg <= cmd.mul_sel;
        end
        if (cmd.div_start)
        begin
            dsel_reg <= cmd.div_sel;
        end
        if (mul_done)
        begin
            unique case (msel_reg)
                MS_CORR: corr_reg <= sat32(corr_wide);
                MS_DTDT: sxx_reg  <= sxx_reg + mul_prod;
                MS_DTDL: sxl_reg  <= sxl_reg + mul_prod;
                MS_DTDP: sxp_reg  <= sxp_reg + mul_prod;
                MS_NSXX: tmp_reg  <= mul_prod;
                MS_SXSX: den_reg  <= tmp_reg - mul_prod;
                MS_NSXL: tmp_reg  <= mul_prod;
                MS_SXSL: nl_reg   <= tmp_reg - mul_prod;
                MS_KL:   nl_reg   <= mul_prod;
                MS_NSXP: tmp_reg  <= mul_prod;
                MS_SXSP: np_reg   <= tmp_reg - mul_prod;
                MS_KP:   np_reg   <= mul_prod;
                default: ;
            endcase
        end
        if (div_done)
        begin
            unique case (dsel_reg)
                DS_LEVEL: lslope_reg <= div_quo;
                DS_TEMP:  tslope_reg <= div_quo;
                DS_RATIO: ratio_reg  <= div_quo;
                default:  ;
            endcase
        end
        if (cmd.store)
        begin
            mem[slot_reg] <= {vent_reg, ret_reg, corr_reg, time_reg};
            base_reg <= slot_reg;
            look_reg <= (win < filled_next) ? win : filled_next;
            idx_reg  <= '0;
            n_reg    <= '0;
            vwin_reg <= 1'b0;
            sx_reg   <= '0;
            sl_reg   <= '0;
            sp_reg   <= '0;
            sxx_reg  <= '0;
            sxl_reg  <= '0;
            sxp_reg  <= '0;
            den_reg  <= '0;
        end
        if (cmd.read)
        begin
            rd_reg <= mem[rd_addr];
        end
        if (cmd.take)
        begin
            if (rd_vent)
            begin
                vwin_reg <= 1'b1;
            end
            else
            begin
                dt_reg <= dt_new;
                dl_reg <= dl_new;
                dp_reg <= dp_new;
                sx_reg <= sx_reg + SX_W'(dt_new);
                sl_reg <= sl_reg + SV_W'(dl_new);
                sp_reg <= sp_reg + SV_W'(dp_new);
                n_reg  <= n_reg + 1'b1;
            end
        end
        if (cmd.advance)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            o_diff_reg   <= sat32(WIDE_W'(diff));
            o_corr_reg   <= corr_reg;
            o_lslope_reg <= lslope_reg;
            o_tslope_reg <= tslope_reg;
            o_ratio_reg  <= ratio_reg;
            o_vent_reg   <= vent_reg;
            o_vwin_reg   <= vwin_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign temp_difference = o_diff_reg;
    assign corrected_level = o_corr_reg;
    assign level_slope     = o_lslope_reg;
    assign temp_slope      = o_tslope_reg;
    assign speed_ratio     = o_ratio_reg;
    assign vent_now        = o_vent_reg;
    assign vent_in_window  = o_vwin_reg;

endmodule
`default_nettype wire

>>> rtl/wsfe_ctrl.sv
// Controller state machine sequencing correction, window walk, fit products and divisions.
`default_nettype none
module wsfe_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire wsfe_pkg::dp_status_t  status,
    output wsfe_pkg::dp_cmd_t          cmd
);
    import wsfe_pkg::*;

    ctrl_state_t state_reg, state_next;
    mul_sel_t    msel_reg, msel_next;
    div_sel_t    dsel_reg, dsel_next;
    logic        issued_reg, issued_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            msel_reg   <= MS_CORR;
            dsel_reg   <= DS_RATIO;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            msel_reg   <= msel_next;
            dsel_reg   <= dsel_next;
            issued_reg <= issued_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        msel_next   = msel_reg;
        dsel_next   = dsel_reg;
        issued_next = issued_reg;
        cmd         = '0;
        cmd.mul_sel = msel_reg;
        cmd.div_sel = dsel_reg;
        in_stall    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    msel_next   = MS_CORR;
                    issued_next = 1'b0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (!issued_reg)
                begin
                    cmd.mul_start = 1'b1;
                    issued_next   = 1'b1;
                end
                else if (status.mul_done)
                begin
                    issued_next = 1'b0;
                    unique case (msel_reg)
                        MS_CORR: state_next = ST_STORE;
                        MS_DTDT: msel_next  = MS_DTDL;
                        MS_DTDL: msel_next  = MS_DTDP;
                        MS_DTDP: state_next = ST_NEXT;
                        MS_NSXX: msel_next  = MS_SXSX;
                        MS_SXSX: msel_next  = MS_NSXL;
                        MS_NSXL: msel_next  = MS_SXSL;
                        MS_SXSL: msel_next  = MS_KL;
                        MS_KL:   msel_next  = MS_NSXP;
                        MS_NSXP: msel_next  = MS_SXSP;
                        MS_SXSP: msel_next  = MS_KP;
                        MS_KP:
                        begin
                            dsel_next  = status.den_pos ? DS_LEVEL : DS_RATIO;
                            state_next = ST_DIV;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_TAKE;
            end
            ST_TAKE:
            begin
                cmd.take = 1'b1;
                if (status.entry_vent)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    msel_next   = MS_DTDT;
                    issued_next = 1'b0;
                    state_next  = ST_MUL;
                end
            end
            ST_NEXT:
            begin
                if (status.last_entry)
                begin
                    issued_next = 1'b0;
                    if (status.fit_points)
                    begin
                        msel_next  = MS_NSXX;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        dsel_next  = DS_RATIO;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_DIV:
            begin
                if (!issued_reg)
                begin
                    cmd.div_start = 1'b1;
                    issued_next   = 1'b1;
                end
                else if (status.div_done)
                begin
                    issued_next = 1'b0;
                    unique case (dsel_reg)
                        DS_LEVEL: dsel_next  = DS_TEMP;
                        DS_TEMP:  dsel_next  = DS_RATIO;
                        DS_RATIO: state_next = ST_FINISH;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> verif/wsfe_checker.sv
// Scan feature predictor and result comparator for the windowed slope feature extractor.
module wsfe_checker
    import wsfe_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic signed [DATA_W-1:0] return_temp,
    input  wire logic signed [DATA_W-1:0] supply_temp,
    input  wire logic signed [DATA_W-1:0] raw_level,
    input  wire logic signed [DATA_W-1:0] pump_speed,
    input  wire logic [TIME_W-1:0]        sample_time,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic signed [DATA_W-1:0] temp_difference,
    input  wire logic signed [DATA_W-1:0] corrected_level,
    input  wire logic signed [DATA_W-1:0] level_slope,
    input  wire logic signed [DATA_W-1:0] temp_slope,
    input  wire logic signed [DATA_W-1:0] speed_ratio,
    input  wire logic                     vent_now,
    input  wire logic                     vent_in_window,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [DATA_W-1:0]        cfg_data,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic [DATA_W-1:0] tdiff;
        logic [DATA_W-1:0] corr;
        logic [DATA_W-1:0] lslope;
        logic [DATA_W-1:0] tslope;
        logic [DATA_W-1:0] ratio;
        logic              vnow;
        logic              vwin;
    } features_t;

    features_t features_q[$];

    logic signed [63:0] coef_r;
    logic signed [63:0] tref_r;
    logic [63:0]        step_r;
    logic [WLEN_W-1:0]  wlen_r;

    logic [TIME_W-1:0]        ring_time [WINDOW_MAX];
    logic signed [DATA_W-1:0] ring_level[WINDOW_MAX];
    logic signed [DATA_W-1:0] ring_temp [WINDOW_MAX];
    logic                     ring_vent [WINDOW_MAX];
    int                       filled;
    logic [SLOT_W-1:0]        slot;
    logic signed [63:0]       prev_raw;
    logic                     prev_seen;
    logic signed [DATA_W-1:0] held_slope;

    assign pending = features_q.size();

    function automatic logic [DATA_W-1:0] clip32(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
        begin
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            return 32'h80000000;
        end
        return v[DATA_W-1:0];
    endfunction

    task automatic report(input string what, input logic [DATA_W-1:0] got,
                          input logic [DATA_W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count = fail_count + 1;
    endtask

    task automatic predict_scan();
        logic signed [63:0]  ret, sup, raw, spd, diff, prod, corr, jump, mag;
        logic [63:0]         absj;
        logic signed [127:0] sx, sl, sp, sxx, sxl, sxp, dt, dl, dp, den, nl, np;
        logic signed [127:0] t0, l0, p0;
        logic [SLOT_W-1:0]   k, newest;
        logic                vent, vwin;
        int                  win, look, n;
        features_t           f;
        ret  = return_temp;
        sup  = supply_temp;
        raw  = raw_level;
        spd  = pump_speed;
        diff = sup - ret;
        prod = coef_r * (ret - tref_r);
        corr = raw - (prod >>> FRAC_BITS);
        f.corr = clip32(corr);
        jump = raw - prev_raw;
        absj = jump < 0 ? -jump : jump;
        vent = prev_seen && (absj > step_r);
        ring_time[slot]  = sample_time;
        ring_level[slot] = f.corr;
        ring_temp[slot]  = return_temp;
        ring_vent[slot]  = vent;
        slot = slot + 1'b1;
        if (filled < WINDOW_MAX)
        begin
            filled = filled + 1;
        end
        win = wlen_r;
        if (win < MIN_FIT_POINTS)
        begin
            win = DEFAULT_WINDOW;
        end
        if (win > WINDOW_MAX)
        begin
            win = WINDOW_MAX;
        end
        look = win < filled ? win : filled;
        newest = slot - 1'b1;
        t0 = $signed({80'b0, ring_time[newest]});
        l0 = ring_level[newest];
        p0 = ring_temp[newest];
        sx = 0; sl = 0; sp = 0; sxx = 0; sxl = 0; sxp = 0;
        n = 0;
        vwin = 1'b0;
        for (int i = 0; i < look; i++)
        begin
            k = newest - SLOT_W'(i);
            if (ring_vent[k])
            begin
                vwin = 1'b1;
            end
            else
            begin
                dt = $signed({80'b0, ring_time[k]}) - t0;
                dl = ring_level[k];
                dl = dl - l0;
                dp = ring_temp[k];
                dp = dp - p0;
                sx  = sx + dt;
                sl  = sl + dl;
                sp  = sp + dp;
                sxx = sxx + dt * dt;
                sxl = sxl + dt * dl;
                sxp = sxp + dt * dp;
                n = n + 1;
            end
        end
        f.lslope = held_slope;
        f.tslope = '0;
        if (n >= MIN_FIT_POINTS)
        begin
            den = 128'(n) * sxx - sx * sx;
            if (den > 0)
            begin
                nl = 128'(n) * sxl - sx * sl;
                np = 128'(n) * sxp - sx * sp;
                f.lslope = clip32((nl * 128'sd1000) / den);
                f.tslope = clip32((np * 128'sd1000) / den);
            end
        end
        held_slope = f.lslope;
        prev_raw   = raw;
        prev_seen  = 1'b1;
        mag = diff < 0 ? -diff : diff;
        if (mag < 64'sd32768)
        begin
            mag = 64'sd32768;
        end
        f.ratio = clip32((spd * 64'sd65536) / mag);
        f.tdiff = clip32(diff);
        f.vnow  = vent;
        f.vwin  = vwin;
        features_q.push_back(f);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_r     <= 0;
            tref_r     <= 0;
            step_r     <= 64'd262144;
            wlen_r     <= WLEN_W'(DEFAULT_WINDOW);
            filled     <= 0;
            slot       <= '0;
            prev_raw   <= 0;
            prev_seen  <= 1'b0;
            held_slope <= '0;
            fail_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (features_q.size() == 0)
                begin
                    report("unexpected item", temp_difference, '0);
                end
                else
                begin
                    features_t w;
                    w = features_q.pop_front();
                    if (temp_difference !== w.tdiff)
                        report("temp_difference", temp_difference, w.tdiff);
                    if (corrected_level !== w.corr)
                        report("corrected_level", corrected_level, w.corr);
                    if (level_slope !== w.lslope)
                        report("level_slope", level_slope, w.lslope);
                    if (temp_slope !== w.tslope)
                        report("temp_slope", temp_slope, w.tslope);
                    if (speed_ratio !== w.ratio)
                        report("speed_ratio", speed_ratio, w.ratio);
                    if (vent_now !== w.vnow)
                        report("vent_now", 32'(vent_now), 32'(w.vnow));
                    if (vent_in_window !== w.vwin)
                        report("vent_in_window", 32'(vent_in_window), 32'(w.vwin));
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_scan();
            end
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_THERMAL_COEF: coef_r <= $signed(cfg_data);
                    REG_REF_TEMP:     tref_r <= $signed(cfg_data);
                    REG_VENT_STEP:    step_r <= {33'b0, cfg_data[STEP_W-1:0]};
                    REG_WINDOW_LEN:   wlen_r <= cfg_data[WLEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> verif/tb.sv
// Stimulus and verdict for the windowed slope feature extractor.
module tb;
    import wsfe_pkg::*;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] return_temp = '0;
    logic signed [DATA_W-1:0] supply_temp = '0;
    logic signed [DATA_W-1:0] raw_level = '0;
    logic signed [DATA_W-1:0] pump_speed = '0;
    logic [TIME_W-1:0]        sample_time = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] temp_difference;
    logic signed [DATA_W-1:0] corrected_level;
    logic signed [DATA_W-1:0] level_slope;
    logic signed [DATA_W-1:0] temp_slope;
    logic signed [DATA_W-1:0] speed_ratio;
    logic                     vent_now;
    logic                     vent_in_window;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]        cfg_data = '0;
    int                       fail_count;
    int                       pending;

    int                       send_idle_pct = 0;
    int                       stall_pct = 0;
    logic [TIME_W-1:0]        scan_time = '0;
    logic signed [DATA_W-1:0] level_now = '0;
    logic signed [DATA_W-1:0] temp_now = '0;

    always #5 clk = ~clk;

    windowed_slope_feature_extractor i_dut (.*);

    wsfe_checker i_checker (.*);

    always @(negedge clk)
    begin
        out_stall = ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        #500000000;
        $display("status: fail");
        $finish;
    end

    task automatic send_scan(input logic [31:0] ret, input logic [31:0] sup,
                             input logic [31:0] raw, input logic [31:0] spd,
                             input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        return_temp = ret;
        supply_temp = sup;
        raw_level   = raw;
        pump_speed  = spd;
        sample_time = t;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (3000) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_scan();
        logic [31:0] ret, sup, raw, spd;
        int          r;
        r = $urandom_range(99);
        if (r < 4)
        begin
            scan_time = TIME_W'({$urandom, $urandom});
        end
        else if (r < 8)
        begin
            scan_time = scan_time;
        end
        else if (r < 10)
        begin
            scan_time = scan_time - $urandom_range(5000);
        end
        else
        begin
            scan_time = scan_time + $urandom_range(1, 4000);
        end
        temp_now = temp_now + $signed($urandom_range(8192)) - 4096;
        level_now = level_now + $signed($urandom_range(65536)) - 32768;
        r = $urandom_range(99);
        if (r < 8)
        begin
            raw = $urandom;
        end
        else if (r < 18)
        begin
            raw = level_now + $signed($urandom_range(1 << 20)) - (1 << 19);
        end
        else
        begin
            raw = level_now;
        end
        ret = ($urandom_range(19) == 0) ? $urandom : temp_now;
        sup = ($urandom_range(9) == 0) ? $urandom
                                       : ret + $signed($urandom_range(1 << 21)) - (1 << 20);
        if ($urandom_range(9) == 0)
        begin
            sup = ret + $signed($urandom_range(65535)) - 32768;
        end
        spd = ($urandom_range(4) == 0) ? $urandom : $urandom_range(1 << 22);
        send_scan(ret, sup, raw, spd, scan_time);
    endtask

    task automatic run_phase(input logic [31:0] coef, input logic [31:0] tref,
                             input logic [31:0] step, input logic [31:0] wlen,
                             input int count);
        drain();
        write_reg(REG_THERMAL_COEF, coef);
        write_reg(REG_REF_TEMP, tref);
        write_reg(REG_VENT_STEP, step);
        write_reg(REG_WINDOW_LEN, wlen);
        repeat (count) random_scan();
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: first scan, field extremes, flat time, vents
        send_scan(32'h0000_0000, 32'h0001_0000, 32'h7fff_ffff, 32'h0001_0000, 48'd0);
        send_scan(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 48'd1000);
        send_scan(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'd2000);
        send_scan(32'h0010_0000, 32'h0010_0000, 32'h8000_0000, 32'h7fff_ffff, 48'd3000);
        send_scan(32'h0010_0000, 32'h0010_0000, 32'h0000_0000, 32'h8000_0000, 48'd4000);
        send_scan(32'h0010_0000, 32'h000f_f000, 32'h0000_1000, 32'hffff_0000, 48'd5000);
        send_scan(32'hffff_ffff, 32'h0000_0000, 32'h0000_2000, 32'hffff_ffff,
                  48'hffff_ffff_ffff);
        for (int i = 0; i < 4; i++)
        begin
            send_scan(32'h0014_0000 + i * 300, 32'h0020_0000, 32'h0000_3000 + i * 700,
                      32'h0002_0000, 48'd7777);
        end
        for (int i = 0; i < 10; i++)
        begin
            send_scan(32'h0014_0000 + i * 1000, 32'h0018_0000, 32'h0005_0000 + i * 9000
                      + ((i == 5) ? 32'h0010_0000 : 0), 32'h0003_0000, 48'd10000 + i * 1000);
        end
        scan_time = 48'd50000;

        send_idle_pct = 37;
        stall_pct = 67;
        run_phase(32'h0001_0000, 32'h0014_0000, 32'h0001_0000, 32'd3, 200);
        run_phase($urandom, $urandom, $urandom, 32'd8, 200);
        run_phase(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'd2, 200);
        send_idle_pct = 67;
        stall_pct = 37;
        run_phase(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'd64, 90);
        run_phase($urandom, $urandom, $urandom, 32'd127, 70);
        run_phase($urandom_range(1 << 17), $urandom, 32'h0004_0000, 32'd0, 200);
        send_idle_pct = 0;
        stall_pct = 0;
        run_phase(32'h0000_0000, 32'h0000_0000, 32'h0004_0000, 32'd16, 200);
        run_phase($urandom, $urandom, $urandom_range(1 << 20),
                  $urandom_range(3, 20), 200);

        drain();
        if (fail_count == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/wsfe_pkg.sv
rtl/wsfe_mul.sv
rtl/wsfe_div.sv
rtl/wsfe_dp.sv
rtl/wsfe_ctrl.sv
rtl/windowed_slope_feature_extractor.sv
verif/wsfe_checker.sv
verif/tb.sv
